[src/fsb_pkg.sv]
// Package for the frame scratch block allocator.
// Holds sequencer states, result status codes, action codes and stream field offsets.
// No dependencies.
package fsb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    STAT_PLACED = 2'd0,
    STAT_OPENED = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_FRAME  = 2'd3
  } status_e;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  // Input tdata layout
  localparam int InSizeLo  = 0;
  localparam int InAlignLo = 40;
  localparam int InUsageLo = 57;
  localparam int InHostBit = 60;
  localparam int InFrameLo = 61;
  localparam int InBits    = 96;

  // Output tdata layout
  localparam int OutBits   = 104;

  localparam logic [2:0] AgeMax = 3'd7;

endpackage

[src/fsb_table.sv]
// Block table memory of the frame scratch block allocator.
// One write port and one read port, read data registered. No package use.
module fsb_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 120
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/frame_scratch_block_allocator.sv]
// Top level of the frame scratch block allocator.
// Depends on fsb_pkg and fsb_table.
//
// Every item, allocate or frame notice, walks the whole block table once, reading one
// slot per cycle from the table memory and, for a frame notice, writing each valid slot
// with a frame no newer than the notice back the next cycle. The read pipeline then
// empties, and an allocate that found a slot writes it in the commit state. A new input
// transfer is taken only once the item in hand has left the commit state. A finished
// result waits in an output register while the next item is taken in; if it is still
// stalled when the next item reaches its commit state, that commit holds until the
// result leaves.
// Slot valid bits sit in flip-flops, so no clearing pass runs after reset.
module frame_scratch_block_allocator #(
  parameter int NUM_SLOTS = 16,
  parameter int SIZE_BITS = 40
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: req_size[39:0], req_alignment[56:40], usage_class[59:57],
  //        host_visible[60], frame_index[92:61], zero fill up to 96 bits
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  // tuser: action[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: slot[3:0], offset[43:4], new_block_size[83:44], released_mask[99:84],
  //        zero fill up to 104 bits
  output logic [103:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int SB = SIZE_BITS;

  typedef struct packed {
    logic [2:0]    usage;
    logic          host;
    logic [SB-1:0] size;
    logic [SB-1:0] fill;
    logic          inflight;
    logic [31:0]   frame;
    logic [2:0]    age;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // Configuration registers
  logic [39:0] min_q;
  logic [2:0]  lim_q;

  fsb_pkg::state_e state_q, state_d;

  // Latched request
  logic          act_q, act_d;
  logic [SB-1:0] size_q, size_d;
  logic [16:0]   m_q, m_d;
  logic [2:0]    usage_q, usage_d;
  logic          host_q, host_d;
  logic [31:0]   frame_q, frame_d;

  // Scan control
  logic [CW-1:0] rd_cnt_q, rd_cnt_d;
  logic          chk_vld_q, chk_vld_d;
  logic [SW-1:0] chk_idx_q, chk_idx_d;

  // Candidates
  logic          lhit_q, lhit_d, fhit_q, fhit_d, free_q, free_d;
  logic [SB-1:0] loff_q, loff_d, foff_q, foff_d, lsize_q, lsize_d, fsize_q, fsize_d;
  logic [SW-1:0] fslot_q, fslot_d, free_slot_q, free_slot_d;
  logic [NUM_SLOTS-1:0] rel_q, rel_d, valid_q, valid_d;
  logic [SW-1:0] last_q, last_d;
  logic          last_vld_q, last_vld_d;

  // Output register
  logic          out_vld_q, out_vld_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [3:0]    out_slot_q, out_slot_d;
  logic [39:0]   out_off_q, out_off_d, out_nbs_q, out_nbs_d;
  logic [15:0]   out_rel_q, out_rel_d;

  // Memory port
  logic          mem_we, mem_re;
  logic [SW-1:0] mem_waddr, mem_raddr;
  entry_t        wr_ent, rd_ent;
  logic [EW-1:0] rdata;

  fsb_table #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (EW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_ent),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  assign rd_ent = entry_t'(rdata);

  // Slot check terms
  logic          vld, compat, fit, lmatch;
  logic [SB:0]   al;
  logic [SB+1:0] endv;
  logic [2:0]    age_new;
  logic [SB-1:0] min_sz, new_sz, sel_off, sel_size;
  logic [SW-1:0] sel_slot;

  always_comb begin
    vld    = valid_q[chk_idx_q];
    al     = ({1'b0, rd_ent.fill} + (SB+1)'(m_q)) & ~((SB+1)'(m_q));
    endv   = (SB+2)'(al) + (SB+2)'(size_q);
    fit    = endv <= (SB+2)'(rd_ent.size);
    compat = vld && (rd_ent.usage == usage_q) && (rd_ent.host == host_q) &&
             (!rd_ent.inflight || (rd_ent.frame == frame_q));
    lmatch = last_vld_q && (chk_idx_q == last_q);
    if (rd_ent.inflight) begin
      age_new = 3'd1;
    end else if (rd_ent.age == fsb_pkg::AgeMax) begin
      age_new = fsb_pkg::AgeMax;
    end else begin
      age_new = rd_ent.age + 3'd1;
    end
    min_sz = SB'(min_q);
    new_sz = (size_q > min_sz) ? size_q : min_sz;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    size_d      = size_q;
    m_d         = m_q;
    usage_d     = usage_q;
    host_d      = host_q;
    frame_d     = frame_q;
    rd_cnt_d    = rd_cnt_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    lhit_d      = lhit_q;
    fhit_d      = fhit_q;
    free_d      = free_q;
    loff_d      = loff_q;
    foff_d      = foff_q;
    lsize_d     = lsize_q;
    fsize_d     = fsize_q;
    fslot_d     = fslot_q;
    free_slot_d = free_slot_q;
    rel_d       = rel_q;
    valid_d     = valid_q;
    last_d      = last_q;
    last_vld_d  = last_vld_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_slot_d  = out_slot_q;
    out_off_d   = out_off_q;
    out_nbs_d   = out_nbs_q;
    out_rel_d   = out_rel_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = chk_idx_q;
    mem_raddr   = rd_cnt_q[SW-1:0];
    wr_ent      = rd_ent;
    sel_slot    = fslot_q;
    sel_off     = foff_q;
    sel_size    = fsize_q;

    case (state_q)
      fsb_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          act_d    = s_axis_tuser[0];
          size_d   = SB'(s_axis_tdata[fsb_pkg::InSizeLo +: 40]);
          m_d      = (s_axis_tdata[fsb_pkg::InAlignLo +: 17] == 17'd0) ? 17'd0 :
                     s_axis_tdata[fsb_pkg::InAlignLo +: 17] - 17'd1;
          usage_d  = s_axis_tdata[fsb_pkg::InUsageLo +: 3];
          host_d   = s_axis_tdata[fsb_pkg::InHostBit];
          frame_d  = s_axis_tdata[fsb_pkg::InFrameLo +: 32];
          rd_cnt_d = '0;
          lhit_d   = 1'b0;
          fhit_d   = 1'b0;
          free_d   = 1'b0;
          rel_d    = '0;
          state_d  = fsb_pkg::ST_SCAN;
        end
      end
      fsb_pkg::ST_SCAN: begin
        // Issue the next slot read
        if (rd_cnt_q < CW'(NUM_SLOTS)) begin
          mem_re    = 1'b1;
          rd_cnt_d  = rd_cnt_q + CW'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = rd_cnt_q[SW-1:0];
        end
        // Examine the slot read last cycle
        if (chk_vld_q) begin
          if (act_q == fsb_pkg::ACT_FRAME) begin
            if (vld && (rd_ent.frame <= frame_q)) begin
              wr_ent.fill     = '0;
              wr_ent.inflight = 1'b0;
              wr_ent.age      = age_new;
              mem_we          = 1'b1;
              if (age_new > lim_q) begin
                valid_d[chk_idx_q] = 1'b0;
                rel_d[chk_idx_q]   = 1'b1;
                if (lmatch) begin
                  last_vld_d = 1'b0;
                end
              end
            end
          end else begin
            if (compat && fit && lmatch) begin
              lhit_d  = 1'b1;
              loff_d  = SB'(al);
              lsize_d = rd_ent.size;
            end
            if (compat && fit && !fhit_q) begin
              fhit_d  = 1'b1;
              fslot_d = chk_idx_q;
              foff_d  = SB'(al);
              fsize_d = rd_ent.size;
            end
            if (!vld && !free_q) begin
              free_d      = 1'b1;
              free_slot_d = chk_idx_q;
            end
          end
        end
        if ((rd_cnt_q == CW'(NUM_SLOTS)) && !chk_vld_q) begin
          state_d = fsb_pkg::ST_COMMIT;
        end
      end
      fsb_pkg::ST_COMMIT: begin
        // Pick the serving slot
        if (lhit_q) begin
          sel_slot = last_q;
          sel_off  = loff_q;
          sel_size = lsize_q;
        end else if (!fhit_q) begin
          sel_slot = free_slot_q;
          sel_off  = '0;
          sel_size = new_sz;
        end
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_slot_d = '0;
          out_off_d  = '0;
          out_nbs_d  = '0;
          out_rel_d  = '0;
          state_d    = fsb_pkg::ST_IDLE;
          if (act_q == fsb_pkg::ACT_FRAME) begin
            out_status_d = fsb_pkg::STAT_FRAME;
            out_rel_d    = 16'(rel_q);
          end else if (lhit_q || fhit_q || free_q) begin
            out_status_d = (lhit_q || fhit_q) ? fsb_pkg::STAT_PLACED : fsb_pkg::STAT_OPENED;
            out_slot_d   = 4'(sel_slot);
            out_off_d    = 40'(sel_off);
            if (!lhit_q && !fhit_q) begin
              out_nbs_d         = 40'(new_sz);
              valid_d[sel_slot] = 1'b1;
            end
            wr_ent.usage    = usage_q;
            wr_ent.host     = host_q;
            wr_ent.size     = sel_size;
            wr_ent.fill     = SB'(sel_off + size_q);
            wr_ent.inflight = 1'b1;
            wr_ent.frame    = frame_q;
            wr_ent.age      = 3'd0;
            mem_waddr       = sel_slot;
            mem_we          = 1'b1;
            last_d          = sel_slot;
            last_vld_d      = 1'b1;
          end else begin
            out_status_d = fsb_pkg::STAT_FULL;
          end
        end
      end
      default: begin
        state_d = fsb_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= fsb_pkg::ST_IDLE;
      rd_cnt_q   <= '0;
      chk_vld_q  <= 1'b0;
      valid_q    <= '0;
      last_q     <= '0;
      last_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      min_q      <= 40'd16777216;
      lim_q      <= 3'd5;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      chk_vld_q  <= chk_vld_d;
      valid_q    <= valid_d;
      last_q     <= last_d;
      last_vld_q <= last_vld_d;
      out_vld_q  <= out_vld_d;
      // Take a register write on the access cycle
      if (psel && penable && pwrite) begin
        if (paddr[3]) begin
          lim_q <= pwdata[2:0];
        end else begin
          min_q <= pwdata[39:0];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    size_q       <= size_d;
    m_q          <= m_d;
    usage_q      <= usage_d;
    host_q       <= host_d;
    frame_q      <= frame_d;
    chk_idx_q    <= chk_idx_d;
    lhit_q       <= lhit_d;
    fhit_q       <= fhit_d;
    free_q       <= free_d;
    loff_q       <= loff_d;
    foff_q       <= foff_d;
    lsize_q      <= lsize_d;
    fsize_q      <= fsize_d;
    fslot_q      <= fslot_d;
    free_slot_q  <= free_slot_d;
    rel_q        <= rel_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_off_q    <= out_off_d;
    out_nbs_q    <= out_nbs_d;
    out_rel_q    <= out_rel_d;
  end

  assign s_axis_tready = (state_q == fsb_pkg::ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {4'd0, out_rel_q, out_nbs_q, out_off_q, out_slot_q};
  assign pready        = 1'b1;
  assign prdata        = paddr[3] ? {61'd0, lim_q} : {24'd0, min_q};

endmodule

[src/fsb_checker.sv]
// Port-level checker for the frame scratch block allocator, with its bind.
// Depends on fsb_pkg.
module fsb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Frame results carry only the released mask
  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == fsb_pkg::STAT_FRAME) |-> m_axis_tdata[83:0] == 84'd0)
    else $error("frame result carries allocation fields");

  // Full results are empty
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == fsb_pkg::STAT_FULL) |-> m_axis_tdata == 104'd0)
    else $error("table full result not empty");

  // Placement in an existing block opens nothing and releases nothing
  a_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == fsb_pkg::STAT_PLACED) |-> m_axis_tdata[103:44] == 60'd0)
    else $error("existing placement reports a size or release");

endmodule

bind frame_scratch_block_allocator fsb_checker u_fsb_checker (.*);
